FILE: design/bfa_pkg.sv
`timescale 1ns / 1ps
package bfa_pkg;

    localparam int unsigned OpcodeW = 1;
    localparam int unsigned OrderW  = 4;
    localparam int unsigned IndexW  = 12;
    localparam int unsigned StatusW = 2;

    typedef enum logic [0:0] {
        OP_ALLOC = 1'b0,
        OP_FREE  = 1'b1
    } t_opcode;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_ORDER_BIG = 2'd1,
        ST_NO_FREE   = 2'd2,
        ST_RANGE     = 2'd3
    } t_status;

    // Sequencer states
    typedef enum logic [4:0] {
        S_INIT,
        S_IDLE,
        S_A_SCAN,
        S_A_RD,
        S_A_RDW,
        S_A_POPN,
        S_A_SPLIT_H,
        S_A_SPLIT_RDW,
        S_A_SPLIT_W,
        S_A_DONE,
        S_F_RDB,
        S_F_RDBW,
        S_F_CHK,
        S_F_LNKW,
        S_F_UNP,
        S_F_UNN,
        S_F_TAGS,
        S_P_RDH,
        S_P_WR,
        S_OUT
    } t_state;

    // Result word
    typedef struct packed {
        logic [StatusW-1:0] status;
        logic [IndexW-1:0]  block_index;
        logic [OrderW-1:0]  size_order;
    } t_result;

endpackage

FILE: design/bfa_if.sv
`timescale 1ns / 1ps
interface bfa_in_if;
    logic                        valid;
    logic                        ready;
    logic [bfa_pkg::OpcodeW-1:0] opcode;
    logic [bfa_pkg::OrderW-1:0]  order;
    logic [bfa_pkg::IndexW-1:0]  frame_index;

    modport source (output valid, opcode, order, frame_index, input ready);
    modport sink   (input valid, opcode, order, frame_index, output ready);
endinterface

interface bfa_out_if;
    logic                        valid;
    logic                        ready;
    logic [bfa_pkg::StatusW-1:0] status;
    logic [bfa_pkg::IndexW-1:0]  block_index;
    logic [bfa_pkg::OrderW-1:0]  size_order;

    modport source (output valid, status, block_index, size_order, input ready);
    modport sink   (input valid, status, block_index, size_order, output ready);
endinterface

FILE: design/bfa_ram.sv
`timescale 1ns / 1ps
module bfa_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port, registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

FILE: design/buddy_frame_allocator_top.sv
`timescale 1ns / 1ps
// Channel   Dir   Payload                              Handshake
// s_in      in    opcode, order, frame_index           valid / ready
// m_out     out   status, block_index, size_order      valid / ready
//
// One word in work at a time; a sequencer drives three frame memories
// (tag, prev, next). Allocate scans the orders upward for a free list,
// pops its head, splits it down to the requested order and tags the block
// allocated; free checks the buddy at each order, merges with a free buddy,
// skips interior levels and pushes the final block.
// After reset a clearing pass over all NUM_FRAMES frames rebuilds the frame table;
// input is not ready during it. The result has its own register, so a new
// word is taken while it waits; a finished word stalls until it is taken.
module buddy_frame_allocator_top #(
    parameter int unsigned NUM_FRAMES = 4096,
    parameter int unsigned TOP_ORDER  = 10
) (
    input  logic i_clk,
    input  logic i_rst_n,
    bfa_in_if.sink    s_in,
    bfa_out_if.source m_out
);
    localparam int unsigned AW    = $clog2(NUM_FRAMES);
    localparam int unsigned LW    = AW + 1;
    localparam int unsigned TW    = 4;
    localparam int unsigned NORD  = TOP_ORDER + 1;
    localparam int unsigned FULL  = (NUM_FRAMES >> TOP_ORDER) << TOP_ORDER;
    localparam int unsigned BLK   = 1 << TOP_ORDER;
    localparam int unsigned OrderW_l = bfa_pkg::OrderW;
    localparam int unsigned IndexW_l = bfa_pkg::IndexW;
    localparam logic [TW-1:0] TagInt = TW'(TOP_ORDER + 1);
    localparam logic [TW-1:0] TagAlc = TW'(TOP_ORDER + 2);
    localparam logic [TW-1:0] TagRsv = TW'(TOP_ORDER + 3);
    localparam logic [LW-1:0] LinkNone = LW'(NUM_FRAMES);

    bfa_pkg::t_state r_state, n_state;

    // list heads and working registers
    logic [LW-1:0] r_head [NORD];
    logic [LW-1:0] n_head [NORD];
    logic [AW-1:0] r_id, n_id;
    logic [AW-1:0] r_b, n_b;
    logic [LW-1:0] r_p, n_p, r_n, n_n;
    logic [OrderW_l-1:0] r_ord, n_ord;
    logic [OrderW_l-1:0] r_j, n_j;
    logic [OrderW_l-1:0] r_req, n_req;
    logic [AW:0] r_init, n_init;
    logic r_alloc, n_alloc;

    // output register
    logic r_ovalid, n_ovalid;
    bfa_pkg::t_result r_res, n_res;
    bfa_pkg::t_result r_odata, n_odata;

    // memory ports
    logic          t_we, p_we, x_we;
    logic [AW-1:0] t_wa, p_wa, x_wa, t_ra, p_ra, x_ra;
    logic [TW-1:0] t_wd, t_rd;
    logic [LW-1:0] p_wd, x_wd, p_rd, x_rd;

    bfa_ram #(.WIDTH(TW), .DEPTH(NUM_FRAMES)) u_tag (
        .i_clk(i_clk), .i_we(t_we), .i_waddr(t_wa), .i_wdata(t_wd),
        .i_raddr(t_ra), .o_rdata(t_rd));
    bfa_ram #(.WIDTH(LW), .DEPTH(NUM_FRAMES)) u_prev (
        .i_clk(i_clk), .i_we(p_we), .i_waddr(p_wa), .i_wdata(p_wd),
        .i_raddr(p_ra), .o_rdata(p_rd));
    bfa_ram #(.WIDTH(LW), .DEPTH(NUM_FRAMES)) u_next (
        .i_clk(i_clk), .i_we(x_we), .i_waddr(x_wa), .i_wdata(x_wd),
        .i_raddr(x_ra), .o_rdata(x_rd));

    function automatic logic is_fr(input logic [LW-1:0] l);
        return l < LW'(NUM_FRAMES);
    endfunction

    // state and registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= bfa_pkg::S_INIT;
            r_init   <= '0;
            r_ovalid <= 1'b0;
            for (int k = 0; k < NORD; k++) begin
                r_head[k] <= (k == TOP_ORDER && FULL > 0) ? '0 : LinkNone;
            end
        end else begin
            r_state  <= n_state;
            r_init   <= n_init;
            r_ovalid <= n_ovalid;
            r_head   <= n_head;
        end
        r_id <= n_id; r_b <= n_b; r_p <= n_p; r_n <= n_n;
        r_ord <= n_ord; r_j <= n_j; r_req <= n_req; r_alloc <= n_alloc;
        r_res <= n_res;
        r_odata <= n_odata;
    end

    assign s_in.ready         = (r_state == bfa_pkg::S_IDLE);
    assign m_out.valid        = r_ovalid;
    assign m_out.status       = r_odata.status;
    assign m_out.block_index  = r_odata.block_index;
    assign m_out.size_order   = r_odata.size_order;

    logic [AW-1:0] w_ia;
    logic [AW:0]   w_half;
    logic [AW:0]   w_bud;
    assign w_ia   = r_init[AW-1:0];
    assign w_half = {1'b0, r_id} + ((AW+1)'(1) << r_j);
    assign w_bud  = {1'b0, r_id ^ AW'((AW+1)'(1) << r_ord)};

    // sequencer
    always_comb begin
        n_state = r_state; n_init = r_init; n_ovalid = r_ovalid; n_head = r_head;
        n_id = r_id; n_b = r_b; n_p = r_p; n_n = r_n; n_ord = r_ord; n_j = r_j;
        n_req = r_req; n_alloc = r_alloc; n_res = r_res; n_odata = r_odata;
        t_we = 1'b0; p_we = 1'b0; x_we = 1'b0;
        t_wa = r_id; p_wa = r_id; x_wa = r_id;
        t_wd = '0; p_wd = LinkNone; x_wd = LinkNone;
        t_ra = r_id; p_ra = r_id; x_ra = r_id;
        if (m_out.valid && m_out.ready) begin
            n_ovalid = 1'b0;
        end
        unique case (r_state)
            bfa_pkg::S_INIT: begin
                // sweep frame table
                t_we = 1'b1; p_we = 1'b1; x_we = 1'b1;
                t_wa = w_ia; p_wa = w_ia; x_wa = w_ia;
                p_wd = LinkNone; x_wd = LinkNone;
                if (32'(r_init) >= FULL) begin
                    t_wd = TagRsv;
                end else if ((32'(r_init) & (BLK - 1)) == 0) begin
                    t_wd = TW'(TOP_ORDER);
                    if (32'(r_init) >= BLK) p_wd = LW'(32'(r_init) - BLK);
                    if (32'(r_init) + BLK < FULL) x_wd = LW'(32'(r_init) + BLK);
                end else begin
                    t_wd = TagInt;
                end
                n_init = r_init + 1'b1;
                if (32'(r_init) == NUM_FRAMES - 1) n_state = bfa_pkg::S_IDLE;
            end
            bfa_pkg::S_IDLE: begin
                if (s_in.valid && s_in.ready) begin
                    n_req = s_in.order;
                    n_j   = s_in.order;
                    n_id  = s_in.frame_index[AW-1:0];
                    if (s_in.opcode == bfa_pkg::OP_ALLOC) begin
                        n_alloc = 1'b1;
                        if (32'(s_in.order) > TOP_ORDER) begin
                            n_res = '{bfa_pkg::ST_ORDER_BIG, '0, '0};
                            n_state = bfa_pkg::S_OUT;
                        end else begin
                            n_state = bfa_pkg::S_A_SCAN;
                        end
                    end else begin
                        n_alloc = 1'b0;
                        n_ord   = '0;
                        if (32'(s_in.frame_index) >= NUM_FRAMES) begin
                            n_res = '{bfa_pkg::ST_RANGE, '0, '0};
                            n_state = bfa_pkg::S_OUT;
                        end else begin
                            n_state = bfa_pkg::S_F_RDB;
                        end
                    end
                end
            end
            bfa_pkg::S_A_SCAN: begin
                // one order per cycle
                if (32'(r_j) > TOP_ORDER) begin
                    n_res = '{bfa_pkg::ST_NO_FREE, '0, '0};
                    n_state = bfa_pkg::S_OUT;
                end else if (is_fr(r_head[r_j])) begin
                    n_id = r_head[r_j][AW-1:0];
                    n_state = bfa_pkg::S_A_RD;
                end else begin
                    n_j = r_j + 1'b1;
                end
            end
            bfa_pkg::S_A_RD: begin
                x_ra = r_id;
                n_state = bfa_pkg::S_A_RDW;
            end
            bfa_pkg::S_A_RDW: begin
                // take next link, clear back link of the popped head
                n_n = x_rd;
                p_we = 1'b1; p_wa = r_id; p_wd = LinkNone;
                n_state = bfa_pkg::S_A_POPN;
            end
            bfa_pkg::S_A_POPN: begin
                // pop head
                if (is_fr(r_n)) begin
                    p_we = 1'b1; p_wa = r_n[AW-1:0]; p_wd = LinkNone;
                    n_head[r_j] = r_n;
                end else begin
                    n_head[r_j] = LinkNone;
                end
                x_we = 1'b1; x_wa = r_id; x_wd = LinkNone;
                n_state = bfa_pkg::S_A_SPLIT_H;
            end
            bfa_pkg::S_A_SPLIT_H: begin
                if (r_j == r_req) begin
                    n_state = bfa_pkg::S_A_DONE;
                end else begin
                    n_j = r_j - 1'b1;
                    n_state = bfa_pkg::S_A_SPLIT_RDW;
                end
            end
            bfa_pkg::S_A_SPLIT_RDW: begin
                if (w_half < (AW+1)'(NUM_FRAMES)) begin
                    n_b = w_half[AW-1:0];
                    n_ord = r_j;
                    n_state = bfa_pkg::S_P_RDH;
                end else begin
                    n_state = bfa_pkg::S_A_SPLIT_H;
                end
            end
            bfa_pkg::S_A_DONE: begin
                t_we = 1'b1; t_wa = r_id; t_wd = TagAlc;
                n_res = '{bfa_pkg::ST_OK, IndexW_l'(r_id), r_req};
                n_state = bfa_pkg::S_OUT;
            end
            bfa_pkg::S_F_RDB: begin
                // check buddy at this order
                if (32'(r_ord) >= TOP_ORDER || w_bud >= (AW+1)'(NUM_FRAMES)) begin
                    n_b = r_id;
                    n_state = bfa_pkg::S_P_RDH;
                end else begin
                    n_b = w_bud[AW-1:0];
                    t_ra = w_bud[AW-1:0]; p_ra = w_bud[AW-1:0]; x_ra = w_bud[AW-1:0];
                    n_state = bfa_pkg::S_F_RDBW;
                end
            end
            bfa_pkg::S_F_RDBW: begin
                n_p = p_rd; n_n = x_rd;
                if (t_rd == TagInt) begin
                    n_ord = r_ord + 1'b1;
                    n_state = bfa_pkg::S_F_RDB;
                end else if (t_rd != TW'(r_ord)) begin
                    n_b = r_id;
                    n_state = bfa_pkg::S_P_RDH;
                end else begin
                    n_state = bfa_pkg::S_F_UNP;
                end
            end
            bfa_pkg::S_F_UNP: begin
                // unlink buddy
                if (is_fr(r_p)) begin
                    x_we = 1'b1; x_wa = r_p[AW-1:0];
                    x_wd = is_fr(r_n) ? r_n : LinkNone;
                end
                if (r_head[r_ord] == {1'b0, r_b}) begin
                    n_head[r_ord] = is_fr(r_n) ? r_n : LinkNone;
                end
                n_state = bfa_pkg::S_F_UNN;
            end
            bfa_pkg::S_F_UNN: begin
                if (is_fr(r_n)) begin
                    p_we = 1'b1; p_wa = r_n[AW-1:0];
                    p_wd = is_fr(r_p) ? r_p : LinkNone;
                end
                t_we = 1'b1; t_wa = r_b; t_wd = TagInt;
                x_we = 1'b1; x_wa = r_b; x_wd = LinkNone;
                n_state = bfa_pkg::S_F_LNKW;
            end
            bfa_pkg::S_F_LNKW: begin
                p_we = 1'b1; p_wa = r_b; p_wd = LinkNone;
                t_we = 1'b1; t_wa = r_id; t_wd = TagInt;
                n_state = bfa_pkg::S_F_TAGS;
            end
            bfa_pkg::S_F_TAGS: begin
                n_id  = r_id & ~AW'((AW+1)'(1) << r_ord);
                n_ord = r_ord + 1'b1;
                n_state = bfa_pkg::S_F_RDB;
            end
            bfa_pkg::S_P_RDH: begin
                // push r_b at order r_ord
                if (is_fr(r_head[r_ord])) begin
                    p_we = 1'b1; p_wa = r_head[r_ord][AW-1:0]; p_wd = {1'b0, r_b};
                end
                x_we = 1'b1; x_wa = r_b;
                x_wd = is_fr(r_head[r_ord]) ? r_head[r_ord] : LinkNone;
                n_state = bfa_pkg::S_P_WR;
            end
            bfa_pkg::S_P_WR: begin
                p_we = 1'b1; p_wa = r_b; p_wd = LinkNone;
                t_we = 1'b1; t_wa = r_b; t_wd = TW'(r_ord);
                n_head[r_ord] = {1'b0, r_b};
                if (r_alloc) begin
                    n_state = bfa_pkg::S_A_SPLIT_H;
                end else begin
                    n_res = '{bfa_pkg::ST_OK, IndexW_l'(r_b), r_ord};
                    n_state = bfa_pkg::S_OUT;
                end
            end
            bfa_pkg::S_OUT: begin
                // hold until the output register is free
                if (!r_ovalid || m_out.ready) begin
                    n_ovalid = 1'b1;
                    n_odata  = r_res;
                    n_state  = bfa_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = bfa_pkg::S_IDLE;
            end
        endcase
    end
endmodule

FILE: sim/buddy_frame_allocator_checker.sv
`timescale 1ns / 1ps
module buddy_frame_allocator_checker #(
    parameter int unsigned NUM_FRAMES = 4096,
    parameter int unsigned TOP_ORDER  = 10
) (
    input  logic i_clk,
    input  logic i_rst_n,
    bfa_in_if.sink    s_in,
    bfa_out_if.sink   m_out,
    output int        o_fail_count,
    output int        o_pending
);
    localparam int unsigned TagInterior  = TOP_ORDER + 1;
    localparam int unsigned TagAllocated = TOP_ORDER + 2;
    localparam int unsigned TagReserved  = TOP_ORDER + 3;
    localparam int unsigned LinkNull     = NUM_FRAMES;

    int unsigned frame_tag [NUM_FRAMES];
    int unsigned prev_link [NUM_FRAMES];
    int unsigned next_link [NUM_FRAMES];
    int unsigned list_head [TOP_ORDER+1];
    bfa_pkg::t_result expected_words[$];
    int          mismatch_count;

    function automatic bit is_frame(int unsigned l);
        return l < NUM_FRAMES;
    endfunction

    function automatic void push_free(int unsigned id, int unsigned ord);
        int unsigned h;
        h = list_head[ord];
        if (is_frame(h)) prev_link[h] = id;
        next_link[id] = is_frame(h) ? h : LinkNull;
        prev_link[id] = LinkNull;
        list_head[ord] = id;
        frame_tag[id] = ord;
    endfunction

    function automatic void unlink_free(int unsigned id, int unsigned ord);
        int unsigned p;
        int unsigned n;
        p = prev_link[id];
        n = next_link[id];
        if (is_frame(p)) next_link[p] = is_frame(n) ? n : LinkNull;
        if (is_frame(n)) prev_link[n] = is_frame(p) ? p : LinkNull;
        prev_link[id] = LinkNull;
        next_link[id] = LinkNull;
        if (list_head[ord] == id) list_head[ord] = is_frame(n) ? n : LinkNull;
    endfunction

    function automatic void reset_frames();
        int unsigned blk;
        int unsigned full;
        blk  = 1 << TOP_ORDER;
        full = (NUM_FRAMES >> TOP_ORDER) << TOP_ORDER;
        for (int unsigned i = 0; i < NUM_FRAMES; i++) begin
            prev_link[i] = LinkNull;
            next_link[i] = LinkNull;
            if (i >= full) begin
                frame_tag[i] = TagReserved;
            end else if ((i & (blk - 1)) == 0) begin
                frame_tag[i] = TOP_ORDER;
                if (i >= blk) prev_link[i] = i - blk;
                if (i + blk < full) next_link[i] = i + blk;
            end else begin
                frame_tag[i] = TagInterior;
            end
        end
        for (int i = 0; i <= TOP_ORDER; i++) list_head[i] = LinkNull;
        if (full > 0) list_head[TOP_ORDER] = 0;
    endfunction

    // Compute the result of one request and update the frame table
    function automatic bfa_pkg::t_result predict_request(bfa_pkg::t_opcode op,
                                                         int unsigned ord,
                                                         int unsigned fi);
        bfa_pkg::t_result r;
        int unsigned i;
        int unsigned j;
        int unsigned id;
        int unsigned b;
        int unsigned n;
        r = '0;
        r.status = bfa_pkg::ST_OK;
        if (op == bfa_pkg::OP_ALLOC) begin
            if (ord > TOP_ORDER) begin
                r.status = bfa_pkg::ST_ORDER_BIG;
            end else begin
                i = ord;
                while (i <= TOP_ORDER && !is_frame(list_head[i])) i++;
                if (i > TOP_ORDER) begin
                    r.status = bfa_pkg::ST_NO_FREE;
                end else begin
                    id = list_head[i];
                    n = next_link[id];
                    if (is_frame(n)) begin
                        prev_link[n] = LinkNull;
                        list_head[i] = n;
                    end else begin
                        list_head[i] = LinkNull;
                    end
                    next_link[id] = LinkNull;
                    prev_link[id] = LinkNull;
                    j = i;
                    while (j > ord) begin
                        j--;
                        if (id + (1 << j) < NUM_FRAMES) push_free(id + (1 << j), j);
                    end
                    frame_tag[id] = TagAllocated;
                    r.block_index = 12'(id);
                    r.size_order  = 4'(ord);
                end
            end
        end else if (fi >= NUM_FRAMES) begin
            r.status = bfa_pkg::ST_RANGE;
        end else begin
            id = fi;
            for (i = 0; i < TOP_ORDER; i++) begin
                b = id ^ (1 << i);
                if (b >= NUM_FRAMES) break;
                if (frame_tag[b] == TagInterior) continue;
                if (frame_tag[b] != i) break;
                unlink_free(b, i);
                frame_tag[b] = TagInterior;
                frame_tag[id] = TagInterior;
                id &= ~(1 << i);
            end
            push_free(id, i);
            r.block_index = 12'(id);
            r.size_order  = 4'(i);
        end
        return r;
    endfunction

    assign o_fail_count = mismatch_count;
    assign o_pending    = expected_words.size();

    // Compare each accepted result word, predict on each accepted request word
    always @(posedge i_clk) begin
        bfa_pkg::t_result got;
        bfa_pkg::t_result exp_word;
        if (!i_rst_n) begin
            reset_frames();
            expected_words.delete();
            mismatch_count = 0;
        end else begin
            if (m_out.valid && m_out.ready) begin
                got.status      = m_out.status;
                got.block_index = m_out.block_index;
                got.size_order  = m_out.size_order;
                if (expected_words.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected result word %h", got);
                end else begin
                    exp_word = expected_words.pop_front();
                    if (got !== exp_word) begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("mismatch: exp st=%0d idx=%0d ord=%0d got st=%0d idx=%0d ord=%0d",
                                     exp_word.status, exp_word.block_index,
                                     exp_word.size_order, got.status,
                                     got.block_index, got.size_order);
                    end
                end
            end
            if (s_in.valid && s_in.ready)
                expected_words.push_back(predict_request(bfa_pkg::t_opcode'(s_in.opcode),
                                                         s_in.order, s_in.frame_index));
        end
    end
endmodule

FILE: sim/buddy_frame_allocator_top_test.sv
`timescale 1ns / 1ps
module buddy_frame_allocator_top_test;
    localparam int CycleLimit = 400000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    int   fail_count;
    int   pending;
    int   cycle_count = 0;
    int unsigned held_blocks[$];

    bfa_in_if  req_ch();
    bfa_out_if rsp_ch();

    buddy_frame_allocator_top uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .s_in(req_ch.sink), .m_out(rsp_ch.source)
    );

    buddy_frame_allocator_checker chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .s_in(req_ch.sink), .m_out(rsp_ch.sink),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Stop a hung run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CycleLimit) begin
            $display("buddy_frame_allocator_top test failed");
            $finish;
        end
    end

    // Random stall on the result side
    initial begin
        int unsigned gap;
        rsp_ch.ready = 1'b0;
        @(posedge i_clk);
        forever begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 3);
            if (gap != 0) begin
                rsp_ch.ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            rsp_ch.ready <= 1'b1;
            @(posedge i_clk);
            while (!(rsp_ch.valid && rsp_ch.ready)) @(posedge i_clk);
        end
    end

    // Send one request word, idle a random gap first
    task automatic send_word(bfa_pkg::t_opcode op, logic [3:0] ord, logic [11:0] idx);
        int unsigned gap;
        gap = $urandom_range(0, 3);
        if (gap != 0) begin
            if (req_ch.valid) req_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.opcode <= op;
        req_ch.order <= ord;
        req_ch.frame_index <= idx;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
    endtask

    // Drop valid after the last word
    task automatic idle_word();
        req_ch.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    initial begin
        int unsigned pick;
        int unsigned k;
        req_ch.valid = 1'b0;
        req_ch.opcode = '0;
        req_ch.order = '0;
        req_ch.frame_index = '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: extremes of orders, errors, frees and merges
        send_word(bfa_pkg::OP_ALLOC, 4'd0, 12'hFFF);
        send_word(bfa_pkg::OP_ALLOC, 4'd15, 12'd0);
        send_word(bfa_pkg::OP_ALLOC, 4'd11, 12'd0);
        send_word(bfa_pkg::OP_ALLOC, 4'd10, 12'd0);
        send_word(bfa_pkg::OP_ALLOC, 4'd10, 12'd0);
        send_word(bfa_pkg::OP_ALLOC, 4'd10, 12'd0);
        send_word(bfa_pkg::OP_ALLOC, 4'd10, 12'd0);
        send_word(bfa_pkg::OP_ALLOC, 4'd0, 12'd0);
        send_word(bfa_pkg::OP_FREE, 4'd0, 12'd0);
        send_word(bfa_pkg::OP_FREE, 4'd15, 12'd1024);
        send_word(bfa_pkg::OP_ALLOC, 4'd10, 12'd0);
        send_word(bfa_pkg::OP_FREE, 4'd0, 12'd3072);
        send_word(bfa_pkg::OP_FREE, 4'd0, 12'd2048);
        send_word(bfa_pkg::OP_FREE, 4'd0, 12'd1);
        send_word(bfa_pkg::OP_FREE, 4'd0, 12'hFFF);
        send_word(bfa_pkg::OP_FREE, 4'd0, 12'h555);
        send_word(bfa_pkg::OP_FREE, 4'd0, 12'hAAA);
        send_word(bfa_pkg::OP_ALLOC, 4'd5, 12'd0);
        send_word(bfa_pkg::OP_ALLOC, 4'd3, 12'd0);

        // Random: mostly allocate/free pairs of real blocks, some noise
        for (int n = 0; n < 800; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 50) begin
                k = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 15)
                                                : $urandom_range(0, 4);
                send_word(bfa_pkg::OP_ALLOC, k[3:0], 12'($urandom));
                idle_word();
                wait (pending == 0);
                // Track handed-out blocks from the response just taken
                if (rsp_ch.status == bfa_pkg::ST_OK)
                    held_blocks.push_back(rsp_ch.block_index);
            end else if (pick < 90 && held_blocks.size() > 0) begin
                k = $urandom_range(0, held_blocks.size() - 1);
                send_word(bfa_pkg::OP_FREE, 4'($urandom), 12'(held_blocks[k]));
                held_blocks.delete(k);
            end else begin
                send_word(bfa_pkg::OP_FREE, 4'($urandom), 12'($urandom));
            end
        end
        idle_word();

        while (pending != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (fail_count == 0)
            $display("buddy_frame_allocator_top test passed");
        else
            $display("buddy_frame_allocator_top test failed");
        $finish;
    end
endmodule
